[rtl/lam_pkg.sv]
// shared types, constants and helpers for the light map block
`timescale 1ns / 1ps
`default_nettype none

package lam_pkg;

    localparam int LAM_MAX_WIDTH  = 1024;
    localparam int LAM_MAX_HEIGHT = 512;

    // compare width for map sizes up to 8191
    localparam int LAM_CMP_W = 13;

    localparam int LAM_CFG_IDX_W  = 3;
    localparam int LAM_CFG_DATA_W = 11;

    localparam logic [2:0] OP_SET_AMBIENT = 3'd0;
    localparam logic [2:0] OP_ADD_WEIGHT  = 3'd1;
    localparam logic [2:0] OP_ADD_FLAT    = 3'd2;
    localparam logic [2:0] OP_MODULATE    = 3'd3;
    localparam logic [2:0] OP_READ        = 3'd4;

    localparam logic [LAM_CFG_IDX_W-1:0] CFG_AMBIENT_RED   = 3'd0;
    localparam logic [LAM_CFG_IDX_W-1:0] CFG_AMBIENT_GREEN = 3'd1;
    localparam logic [LAM_CFG_IDX_W-1:0] CFG_AMBIENT_BLUE  = 3'd2;
    localparam logic [LAM_CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd3;
    localparam logic [LAM_CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd4;

    localparam logic [10:0] MAP_WIDTH_RESET  = 11'd640;
    localparam logic [9:0]  MAP_HEIGHT_RESET = 10'd480;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MULT,
        S_WRITE
    } t_lam_state;

    typedef struct packed {
        logic load;
        logic check;
        logic mult;
        logic finish;
    } t_lam_cmd;

    typedef struct packed {
        logic op_ok;
        logic in_range;
    } t_lam_status;

    function automatic logic [7:0] sat_add(input logic [7:0] l, input logic [7:0] d);
        logic [8:0] s;
        s = {1'b0, l} + {1'b0, d};
        return s[8] ? 8'hff : s[7:0];
    endfunction

endpackage

`default_nettype wire

[rtl/lam_ctrl.sv]
// sequencing state machine for the light map read-modify-write
`timescale 1ns / 1ps
`default_nettype none

module lam_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire lam_pkg::t_lam_status i_status,
    output lam_pkg::t_lam_cmd         o_cmd,
    output logic                      o_busy
);
    import lam_pkg::*;

    t_lam_state r_state;
    t_lam_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_status.op_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.in_range ? S_READ : S_WRITE;
            end
            S_READ:  n_state = S_MULT;
            S_MULT:  n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_CHECK: o_cmd.check  = 1'b1;
            S_READ:  o_cmd        = '0;
            S_MULT:  o_cmd.mult   = 1'b1;
            S_WRITE: o_cmd.finish = 1'b1;
            default: o_cmd        = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/lam_dp.sv]
// light map datapath: config registers, light store, multipliers, result registers
`timescale 1ns / 1ps
`default_nettype none

module lam_dp #(
    parameter int MAX_WIDTH  = lam_pkg::LAM_MAX_WIDTH,
    parameter int MAX_HEIGHT = lam_pkg::LAM_MAX_HEIGHT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire lam_pkg::t_lam_cmd                    i_cmd,
    output lam_pkg::t_lam_status                      o_status,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [lam_pkg::LAM_CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lam_pkg::LAM_CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [2:0]                           i_op,
    input  wire logic signed [11:0]                   i_pos_x,
    input  wire logic signed [11:0]                   i_pos_y,
    input  wire logic [7:0]                           i_in_red,
    input  wire logic [7:0]                           i_in_green,
    input  wire logic [7:0]                           i_in_blue,
    input  wire logic [7:0]                           i_in_alpha,
    output logic                                      o_valid,
    output logic [7:0]                                o_out_red,
    output logic [7:0]                                o_out_green,
    output logic [7:0]                                o_out_blue,
    output logic [7:0]                                o_out_alpha,
    output logic                                      o_in_range
);
    import lam_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);

    // config registers
    logic [7:0]  r_amb [3];
    logic [10:0] r_map_width;
    logic [9:0]  r_map_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb[0]     <= '0;
            r_amb[1]     <= '0;
            r_amb[2]     <= '0;
            r_map_width  <= MAP_WIDTH_RESET;
            r_map_height <= MAP_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AMBIENT_RED:   r_amb[0]     <= i_cfg_data[7:0];
                CFG_AMBIENT_GREEN: r_amb[1]     <= i_cfg_data[7:0];
                CFG_AMBIENT_BLUE:  r_amb[2]     <= i_cfg_data[7:0];
                CFG_MAP_WIDTH:     r_map_width  <= i_cfg_data[10:0];
                CFG_MAP_HEIGHT:    r_map_height <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // latched transaction
    logic [2:0]         r_op;
    logic signed [11:0] r_x;
    logic signed [11:0] r_y;
    logic [7:0]         r_c [3];
    logic [7:0]         r_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_c[0] <= i_in_red;
            r_c[1] <= i_in_green;
            r_c[2] <= i_in_blue;
            r_a    <= i_in_alpha;
        end
    end

    assign o_status.op_ok = (i_op inside {OP_SET_AMBIENT, OP_ADD_WEIGHT, OP_ADD_FLAT,
                                          OP_MODULATE, OP_READ});

    // range check and address
    logic [LAM_CMP_W-1:0] w_eff;
    logic [LAM_CMP_W-1:0] h_eff;
    logic                 in_rng;
    logic [AW-1:0]        n_addr;

    always_comb begin
        w_eff = (LAM_CMP_W'(r_map_width) > LAM_CMP_W'(MAX_WIDTH)) ?
                LAM_CMP_W'(MAX_WIDTH) : LAM_CMP_W'(r_map_width);
        h_eff = (LAM_CMP_W'(r_map_height) > LAM_CMP_W'(MAX_HEIGHT)) ?
                LAM_CMP_W'(MAX_HEIGHT) : LAM_CMP_W'(r_map_height);
        in_rng = !r_x[11] && !r_y[11] &&
                 (LAM_CMP_W'(r_x[10:0]) < w_eff) && (LAM_CMP_W'(r_y[10:0]) < h_eff);
        n_addr = AW'(r_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(r_x[XW-1:0]);
    end

    assign o_status.in_range = in_rng;

    logic          r_range;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_range <= in_rng;
            r_addr  <= n_addr;
        end
    end

    // light store
    logic [23:0] mem [DEPTH];
    logic [23:0] r_rd_data;
    logic        wr_en;
    logic [23:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        r_rd_data <= mem[r_addr];
    end

    // products
    logic [7:0]  r_light [3];
    logic [15:0] r_prod_a [3];
    logic [15:0] r_prod_l [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            for (int i = 0; i < 3; i++) begin
                r_light[i]  <= r_rd_data[8*i +: 8];
                r_prod_a[i] <= 16'(r_c[i]) * 16'(r_a);
                r_prod_l[i] <= 16'(r_c[i]) * 16'(r_rd_data[8*i +: 8]);
            end
        end
    end

    // update and result
    logic       white;
    logic [7:0] new_l [3];
    logic [7:0] res   [3];
    logic [7:0] res_a;

    always_comb begin
        white = (r_light[0] == 8'hff) && (r_light[1] == 8'hff) && (r_light[2] == 8'hff);
        res_a = '0;
        for (int i = 0; i < 3; i++) begin
            new_l[i] = r_light[i];
            res[i]   = r_light[i];
        end
        case (r_op)
            OP_SET_AMBIENT: begin
                for (int i = 0; i < 3; i++) new_l[i] = r_amb[i];
            end
            OP_ADD_WEIGHT: begin
                for (int i = 0; i < 3; i++) begin
                    if (!white && r_c[i] != 8'd0) begin
                        new_l[i] = sat_add(r_light[i], r_prod_a[i][15:8]);
                    end
                end
            end
            OP_ADD_FLAT: begin
                for (int i = 0; i < 3; i++) new_l[i] = sat_add(r_light[i], r_c[i]);
            end
            OP_MODULATE: begin
                for (int i = 0; i < 3; i++) res[i] = white ? r_c[i] : r_prod_l[i][15:8];
                res_a = r_a;
            end
            default: ;
        endcase
        if (r_op != OP_MODULATE) begin
            for (int i = 0; i < 3; i++) res[i] = new_l[i];
        end
        wr_en   = i_cmd.finish && r_range &&
                  (r_op inside {OP_SET_AMBIENT, OP_ADD_WEIGHT, OP_ADD_FLAT});
        wr_data = {new_l[2], new_l[1], new_l[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_red   <= r_range ? res[0] : 8'd0;
            o_out_green <= r_range ? res[1] : 8'd0;
            o_out_blue  <= r_range ? res[2] : 8'd0;
            o_out_alpha <= r_range ? res_a  : 8'd0;
            o_in_range  <= r_range;
        end
    end

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_off_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_out_red == 8'd0 && o_out_green == 8'd0 &&
                                     o_out_blue == 8'd0 && o_out_alpha == 8'd0))
        else $error("off-map result carries nonzero fields");

    a_alpha_modulate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_alpha != 8'd0) |-> (r_op == OP_MODULATE))
        else $error("alpha passed through on a non-modulate transaction");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_range && $past(i_cmd.mult || i_cmd.check)))
        else $error("light store written outside the update step");

endmodule

`default_nettype wire

[rtl/lightmap_accumulate_modulate_core.sv]
// top level of the light map accumulate and modulate block
`timescale 1ns / 1ps
`default_nettype none

// Light map block. A transaction is taken when i_start is high and o_busy is low.
// An on-map transaction passes the check, read, multiply and write-back steps
// on the single-port light store before its result strobe o_valid is high; an
// off-map one skips the read and multiply. o_busy drops in the cycle of the
// strobe, so a new transaction can be taken in that cycle. Op codes 5 to 7 leave
// the block idle and produce no result. The result strobe lasts one cycle and
// cannot be held off. The light store is not cleared after reset: a pixel must
// be set by op 0 before it is read. The configuration port is always ready; the
// user must write it only while o_busy is low and no result is pending, which
// the block itself does not enforce.
module lightmap_accumulate_modulate_core #(
    parameter int MAX_WIDTH  = lam_pkg::LAM_MAX_WIDTH,
    parameter int MAX_HEIGHT = lam_pkg::LAM_MAX_HEIGHT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    output logic                                      o_busy,
    input  wire logic [2:0]                           i_op,
    input  wire logic signed [11:0]                   i_pos_x,
    input  wire logic signed [11:0]                   i_pos_y,
    input  wire logic [7:0]                           i_in_red,
    input  wire logic [7:0]                           i_in_green,
    input  wire logic [7:0]                           i_in_blue,
    input  wire logic [7:0]                           i_in_alpha,
    output logic                                      o_valid,
    output logic [7:0]                                o_out_red,
    output logic [7:0]                                o_out_green,
    output logic [7:0]                                o_out_blue,
    output logic [7:0]                                o_out_alpha,
    output logic                                      o_in_range,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [lam_pkg::LAM_CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lam_pkg::LAM_CFG_DATA_W-1:0]   i_cfg_data
);
    import lam_pkg::*;

    t_lam_cmd    cmd;
    t_lam_status status;
    logic        busy;

    assign o_busy      = busy;
    assign o_cfg_ready = 1'b1;

    lam_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lam_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_in_range  (o_in_range)
    );

endmodule

`default_nettype wire

[test/tb_lightmap_accumulate_modulate_core.sv]
// testbench for the light map core: self-checking pixel commands against a behavioral mirror
`timescale 1ns / 1ps

module tb_lightmap_accumulate_modulate_core;
    import lam_pkg::*;

    typedef struct {
        logic [2:0]        op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [7:0]        a;
    } t_light_cmd;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       in_range;
    } t_light_result;

    class pixel_mirror;
        logic [23:0]   light_level [int];
        int            lit_addr [$];
        t_light_result due_pixels [$];
        logic [7:0]    amb_r;
        logic [7:0]    amb_g;
        logic [7:0]    amb_b;
        logic [10:0]   map_w;
        logic [9:0]    map_h;
        int            faults;
        int            results_seen;

        function new();
            amb_r = 8'd0;
            amb_g = 8'd0;
            amb_b = 8'd0;
            map_w = MAP_WIDTH_RESET;
            map_h = MAP_HEIGHT_RESET;
            faults = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [LAM_CFG_IDX_W-1:0] idx,
                                   logic [LAM_CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AMBIENT_RED: begin
                    amb_r = data[7:0];
                end
                CFG_AMBIENT_GREEN: begin
                    amb_g = data[7:0];
                end
                CFG_AMBIENT_BLUE: begin
                    amb_b = data[7:0];
                end
                CFG_MAP_WIDTH: begin
                    map_w = data[10:0];
                end
                CFG_MAP_HEIGHT: begin
                    map_h = data[9:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int eff_width();
            return (map_w > LAM_MAX_WIDTH) ? LAM_MAX_WIDTH : int'(map_w);
        endfunction

        function int eff_height();
            return (map_h > LAM_MAX_HEIGHT) ? LAM_MAX_HEIGHT : int'(map_h);
        endfunction

        function logic [7:0] light_sum(logic [7:0] l, logic [7:0] d);
            return (9'(l) + 9'(d) > 9'd255) ? 8'hff : l + d;
        endfunction

        function t_light_result shade_pixel(t_light_cmd c);
            t_light_result res;
            int            xi;
            int            yi;
            int            addr;
            logic [23:0]   word;
            logic [7:0]    lvl [3];
            logic [7:0]    src [3];
            logic [15:0]   prod;
            bit            white;
            res.r = 8'd0;
            res.g = 8'd0;
            res.b = 8'd0;
            res.a = 8'd0;
            res.in_range = 1'b0;
            xi = c.x;
            yi = c.y;
            if (xi < 0 || yi < 0 || xi >= eff_width() || yi >= eff_height()) begin
                return res;
            end
            addr = yi * LAM_MAX_WIDTH + xi;
            word = light_level.exists(addr) ? light_level[addr] : 24'h0;
            src = '{c.r, c.g, c.b};
            for (int i = 0; i < 3; i++) begin
                lvl[i] = word[8*i +: 8];
            end
            white = (word == 24'hffffff);
            case (c.op)
                OP_SET_AMBIENT: begin
                    lvl = '{amb_r, amb_g, amb_b};
                end
                OP_ADD_WEIGHT: begin
                    if (!white) begin
                        for (int i = 0; i < 3; i++) begin
                            if (src[i] != 8'd0) begin
                                prod = {8'd0, src[i]} * {8'd0, c.a};
                                lvl[i] = light_sum(lvl[i], prod[15:8]);
                            end
                        end
                    end
                end
                OP_ADD_FLAT: begin
                    for (int i = 0; i < 3; i++) begin
                        lvl[i] = light_sum(lvl[i], src[i]);
                    end
                end
                default: begin
                end
            endcase
            if (c.op <= OP_ADD_FLAT) begin
                if (!light_level.exists(addr)) begin
                    lit_addr.push_back(addr);
                end
                light_level[addr] = {lvl[2], lvl[1], lvl[0]};
            end
            if (c.op == OP_MODULATE) begin
                for (int i = 0; i < 3; i++) begin
                    prod = {8'd0, src[i]} * {8'd0, lvl[i]};
                    lvl[i] = white ? src[i] : prod[15:8];
                end
                res.a = c.a;
            end
            res.r = lvl[0];
            res.g = lvl[1];
            res.b = lvl[2];
            res.in_range = 1'b1;
            return res;
        endfunction

        function void take_command(t_light_cmd c);
            if (c.op > OP_READ) begin
                return;
            end
            due_pixels.push_back(shade_pixel(c));
        endfunction

        function void match_field(string tag, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, tag, want, got);
                faults++;
            end
        endfunction

        function void compare_result(t_light_result got);
            t_light_result want;
            if (due_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none actual r=%0h g=%0h b=%0h a=%0h in=%0b",
                         $time, got.r, got.g, got.b, got.a, got.in_range);
                faults++;
                return;
            end
            want = due_pixels.pop_front();
            results_seen++;
            match_field("red", want.r, got.r);
            match_field("green", want.g, got.g);
            match_field("blue", want.b, got.b);
            match_field("alpha", want.a, got.a);
            match_field("in_range", {7'd0, want.in_range}, {7'd0, got.in_range});
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    logic [2:0]                 i_op;
    logic signed [11:0]         i_pos_x;
    logic signed [11:0]         i_pos_y;
    logic [7:0]                 i_in_red;
    logic [7:0]                 i_in_green;
    logic [7:0]                 i_in_blue;
    logic [7:0]                 i_in_alpha;
    logic                       o_valid;
    logic [7:0]                 o_out_red;
    logic [7:0]                 o_out_green;
    logic [7:0]                 o_out_blue;
    logic [7:0]                 o_out_alpha;
    logic                       o_in_range;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [LAM_CFG_IDX_W-1:0]   i_cfg_index;
    logic [LAM_CFG_DATA_W-1:0]  i_cfg_data;

    pixel_mirror   sb = new();
    t_light_result seen_pixel;
    int            cmd_count;
    int            ignored_count;
    int            cfg_writes;
    int            setups;

    lightmap_accumulate_modulate_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_op       (i_op),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_in_red   (i_in_red),
        .i_in_green (i_in_green),
        .i_in_blue  (i_in_blue),
        .i_in_alpha (i_in_alpha),
        .o_valid    (o_valid),
        .o_out_red  (o_out_red),
        .o_out_green(o_out_green),
        .o_out_blue (o_out_blue),
        .o_out_alpha(o_out_alpha),
        .o_in_range (o_in_range),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("lightmap_accumulate_modulate_core regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_pixel.r = o_out_red;
            seen_pixel.g = o_out_green;
            seen_pixel.b = o_out_blue;
            seen_pixel.a = o_out_alpha;
            seen_pixel.in_range = o_in_range;
            sb.compare_result(seen_pixel);
        end
    end

    function automatic t_light_cmd mk(logic [2:0] op, int x, int y,
                                      int r, int g, int b, int a);
        t_light_cmd c;
        c.op = op;
        c.x = 12'(x);
        c.y = 12'(y);
        c.r = 8'(r);
        c.g = 8'(g);
        c.b = 8'(b);
        c.a = 8'(a);
        return c;
    endfunction

    function automatic logic [7:0] chan();
        int k;
        k = $urandom_range(99);
        if (k < 15) begin
            return 8'd0;
        end else if (k < 30) begin
            return 8'hff;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic issue(t_light_cmd c);
        i_start <= 1'b1;
        i_op <= c.op;
        i_pos_x <= c.x;
        i_pos_y <= c.y;
        i_in_red <= c.r;
        i_in_green <= c.g;
        i_in_blue <= c.b;
        i_in_alpha <= c.a;
        do @(posedge i_clk); while (o_busy);
        sb.take_command(c);
        if (c.op <= OP_READ) begin
            cmd_count++;
        end else begin
            ignored_count++;
        end
    endtask

    task automatic idle_gap(int pct);
        int n;
        n = 0;
        while (n < 12 && $urandom_range(99) < pct) begin
            n++;
        end
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drain every pending result, then let a trailing ignored code finish
    task automatic settle();
        i_start <= 1'b0;
        while (sb.due_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_setup(int w, int h, int ar, int ag, int ab);
        logic [LAM_CFG_DATA_W-1:0] vals [5];
        logic [LAM_CFG_IDX_W-1:0]  idx [5];
        vals = '{11'(ar), 11'(ag), 11'(ab), 11'(w), 11'(h)};
        idx = '{CFG_AMBIENT_RED, CFG_AMBIENT_GREEN, CFG_AMBIENT_BLUE,
                CFG_MAP_WIDTH, CFG_MAP_HEIGHT};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_register(idx[i], vals[i]);
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
        setups++;
    endtask

    task automatic place_any(inout t_light_cmd c, input int w, input int h);
        int k;
        k = $urandom_range(9);
        if (k < 6) begin
            c.x = 12'($urandom_range((w < 8 ? w : 8) - 1));
            c.y = 12'($urandom_range((h < 4 ? h : 4) - 1));
        end else if (k < 9) begin
            c.x = 12'($urandom_range(w - 1));
            c.y = 12'($urandom_range(h - 1));
        end else begin
            c.x = 12'($urandom_range(1) ? w - 1 : 0);
            c.y = 12'($urandom_range(1) ? h - 1 : 0);
        end
    endtask

    // only pixels already set by the ambient op may be read back
    function automatic bit pick_lit(inout t_light_cmd c, input int w, input int h);
        int x;
        int y;
        int addr;
        x = $urandom_range((w < 8 ? w : 8) - 1);
        y = $urandom_range((h < 4 ? h : 4) - 1);
        if (sb.light_level.exists(y * LAM_MAX_WIDTH + x)) begin
            c.x = 12'(x);
            c.y = 12'(y);
            return 1'b1;
        end
        if (sb.lit_addr.size() == 0) begin
            return 1'b0;
        end
        repeat (6) begin
            addr = sb.lit_addr[$urandom_range(sb.lit_addr.size() - 1)];
            x = addr % LAM_MAX_WIDTH;
            y = addr / LAM_MAX_WIDTH;
            if (x < w && y < h) begin
                c.x = 12'(x);
                c.y = 12'(y);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic random_item(int pct);
        t_light_cmd c;
        int         w;
        int         h;
        int         roll;
        int         k;
        w = sb.eff_width();
        h = sb.eff_height();
        c.r = chan();
        c.g = chan();
        c.b = chan();
        c.a = chan();
        c.x = 12'($urandom);
        c.y = 12'($urandom);
        roll = $urandom_range(99);
        if (roll < 4) begin
            c.op = 3'($urandom_range(7, 5));
        end else if (w == 0 || h == 0) begin
            c.op = 3'($urandom_range(4));
        end else if (roll < 12) begin
            c.op = 3'($urandom_range(4));
            case ($urandom_range(3))
                0: c.x = 12'(-int'($urandom_range(2048, 1)));
                1: c.x = 12'($urandom_range(2047, w));
                2: c.y = 12'(-int'($urandom_range(2048, 1)));
                default: c.y = 12'($urandom_range(2047, h));
            endcase
        end else if (roll < 30 || !pick_lit(c, w, h)) begin
            c.op = OP_SET_AMBIENT;
            place_any(c, w, h);
        end else begin
            k = $urandom_range(9);
            if (k < 3) begin
                c.op = OP_ADD_WEIGHT;
            end else if (k < 5) begin
                c.op = OP_ADD_FLAT;
            end else if (k < 8) begin
                c.op = OP_MODULATE;
            end else begin
                c.op = OP_READ;
            end
        end
        idle_gap(pct);
        issue(c);
    endtask

    task automatic run_phase(int w, int h, int ar, int ag, int ab, int pct, int n);
        int start_count;
        settle();
        write_setup(w, h, ar, ag, ab);
        start_count = cmd_count;
        while (cmd_count - start_count < n) begin
            random_item(pct);
        end
    endtask

    initial begin : main
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_op <= OP_READ;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_in_red <= '0;
        i_in_green <= '0;
        i_in_blue <= '0;
        i_in_alpha <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_AMBIENT_RED;
        i_cfg_data <= '0;
        cmd_count = 0;
        ignored_count = 0;
        cfg_writes = 0;
        setups = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset map 640x480, ambient black
        issue(mk(OP_SET_AMBIENT, 0, 0, 9, 9, 9, 9));
        issue(mk(OP_READ, 0, 0, 255, 255, 255, 255));
        issue(mk(OP_ADD_WEIGHT, 0, 0, 255, 0, 128, 255));
        issue(mk(OP_ADD_WEIGHT, 0, 0, 200, 100, 50, 0));
        issue(mk(OP_ADD_FLAT, 0, 0, 255, 255, 255, 0));
        issue(mk(OP_ADD_WEIGHT, 0, 0, 255, 255, 255, 255));
        issue(mk(OP_MODULATE, 0, 0, 18, 52, 86, 120));
        idle_gap(100);
        issue(mk(OP_SET_AMBIENT, 639, 479, 0, 0, 0, 0));
        issue(mk(OP_ADD_FLAT, 639, 479, 1, 2, 3, 0));
        issue(mk(OP_MODULATE, 639, 479, 255, 255, 255, 170));
        issue(mk(OP_READ, 639, 479, 0, 0, 0, 0));
        issue(mk(OP_SET_AMBIENT, 1, 0, 0, 0, 0, 0));
        issue(mk(OP_ADD_FLAT, 1, 0, 128, 64, 255, 0));
        issue(mk(OP_MODULATE, 1, 0, 255, 128, 1, 85));
        issue(mk(OP_READ, 640, 0, 0, 0, 0, 0));
        issue(mk(OP_ADD_FLAT, 0, 480, 10, 10, 10, 0));
        issue(mk(OP_SET_AMBIENT, -1, 5, 0, 0, 0, 0));
        issue(mk(OP_MODULATE, -2048, 2047, 255, 255, 255, 255));
        issue(mk(OP_ADD_WEIGHT, 2047, -2048, 255, 255, 255, 255));
        issue(mk(3'd5, 0, 0, 1, 1, 1, 1));
        issue(mk(3'd6, 1, 0, 1, 1, 1, 1));
        issue(mk(3'd7, -1, -1, 255, 255, 255, 255));
        issue(mk(OP_READ, 1, 0, 0, 0, 0, 0));

        run_phase(1024, 512, 16, 128, 255, 0, 120);
        run_phase(2047, 1023, 255, 255, 255, 55, 110);
        run_phase(1, 1, 0, 0, 0, 0, 60);
        run_phase(0, 0, 'h7c3, 'h1ff, 'h400, 29, 60);
        run_phase(17, 9, $urandom_range(255), $urandom_range(255), $urandom_range(255), 55, 110);
        run_phase(1, 512, $urandom_range(255), $urandom_range(255), $urandom_range(255), 0, 130);
        run_phase(640, 480, $urandom_range(255), $urandom_range(255), $urandom_range(255), 29, 120);
        run_phase(1023, 511, $urandom_range(255), $urandom_range(255), $urandom_range(255), 55, 140);

        settle();
        if (sb.due_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.due_pixels.size());
            sb.faults++;
        end
        $display("%0d pixel commands and %0d unused op codes sent, %0d results checked",
                 cmd_count, ignored_count, sb.results_seen);
        $display("%0d register writes over %0d map setups, zero, single-pixel and clamped sizes",
                 cfg_writes, setups);
        if (sb.faults == 0) begin
            $display("lightmap_accumulate_modulate_core regression: pass");
        end else begin
            $display("lightmap_accumulate_modulate_core regression: fail");
        end
        $finish;
    end

endmodule
